// File: src/brl_pkg.sv
// Shared constants, codes and types of the Bloom-filtered IPv4 route lookup block.
package brl_pkg;

    // Table geometry.
    localparam int DIRECT_INDEX_BITS = 20;
    localparam int BLOOM_BITS        = 65536;
    localparam int BUCKETS           = 16384;
    localparam int WAYS              = 4;
    localparam int MAX_HASHES        = 16;

    // Derived widths.
    localparam int BLOOM_AW  = $clog2(BLOOM_BITS);
    localparam int BUCKET_AW = $clog2(BUCKETS);
    localparam int WAY_AW    = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ENTRY_AW  = BUCKET_AW + WAY_AW;
    localparam int CLR_AW0   = (DIRECT_INDEX_BITS > BLOOM_AW) ? DIRECT_INDEX_BITS : BLOOM_AW;
    localparam int CLR_AW    = (CLR_AW0 > ENTRY_AW) ? CLR_AW0 : ENTRY_AW;
    localparam int DIV_W0    = $clog2(BLOOM_BITS + 1);
    localparam int DIV_W1    = $clog2(BUCKETS + 1);
    localparam int DIV_W     = (DIV_W0 > DIV_W1) ? DIV_W0 : DIV_W1;
    localparam int PROBE_W   = $clog2(MAX_HASHES + 1);
    localparam int DRAW_W    = 31;

    // Field widths.
    localparam int ADDR_W     = 32;
    localparam int PLEN_W     = 6;
    localparam int STATUS_W   = 2;
    localparam int CNT_W      = 5;
    localparam int LEN_W      = 17;
    localparam int BKT_W      = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Hash generator constants.
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;

    localparam logic [ADDR_W-1:0] ALL_ONES   = 32'hffffffff;
    localparam logic [ADDR_W-1:0] NET24_MASK = 32'hffffff00;
    localparam logic [PLEN_W-1:0] HOST_PLEN  = 6'd32;
    localparam logic [PLEN_W-1:0] DIRECT_PLEN = PLEN_W'(DIRECT_INDEX_BITS);

    // Operation codes.
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_STORE  = 1'b1;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_BADLEN = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_HOST_CNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NET_CNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOST_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NET_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOST_BKT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NET_BKT  = 3'd5;

    // One exact-match table entry.
    typedef struct packed {
        logic        valid;
        logic [31:0] key;
        logic [31:0] hop;
    } entry_t;

endpackage

// File: src/brl_if.sv
// Request, response and configuration channel interfaces of the route lookup block.
interface brl_req_if;
    import brl_pkg::*;
    logic                valid;
    logic                ready;
    logic                op;
    logic [ADDR_W-1:0]   addr;
    logic [PLEN_W-1:0]   prefix_len;
    logic [ADDR_W-1:0]   hop_in;
    modport source (output valid, op, addr, prefix_len, hop_in, input ready);
    modport sink (input valid, op, addr, prefix_len, hop_in, output ready);
endinterface

interface brl_rsp_if;
    import brl_pkg::*;
    logic                valid;
    logic                ready;
    logic                found;
    logic [ADDR_W-1:0]   next_hop_out;
    logic                created;
    logic [STATUS_W-1:0] status;
    modport source (output valid, found, next_hop_out, created, status, input ready);
    modport sink (input valid, found, next_hop_out, created, status, output ready);
endinterface

interface brl_cfg_if;
    import brl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// File: src/bloom_ip_route_lookup_unit.sv
// Top level of the Bloom-filtered IPv4 route lookup engine.
//
//   Channel | Dir | Payload                                  | Request taken when
//   --------+-----+------------------------------------------+---------------------
//   req     | in  | op, addr, prefix_len, hop_in             | req.valid & req.ready
//   rsp     | out | found, next_hop_out, created, status     | rsp.valid & rsp.ready
//   cfg     | in  | index, data                              | cfg.valid & cfg.ready
//
// One request is worked on at a time. Each Bloom probe runs the hash generator (one
// 32-bit multiply per step), then the bit-serial remainder unit over the 31-bit draw,
// then a bloom memory read. A bucket search hashes the key the same way and then
// reads and checks the ways one at a time. A lookup that misses everywhere probes the
// host group, then the net group, then the direct table; a store works on one group.
// After reset a clearing pass writes zero through every memory, walking 2**CLR_AW
// addresses (1048576 here); req.ready stays low meanwhile, while cfg writes are always taken.
// A result waits in the output register when rsp stalls; the next request is then
// already accepted and the engine only holds before overwriting the pending result.
module bloom_ip_route_lookup_unit import brl_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    brl_req_if.sink   req,
    brl_rsp_if.source rsp,
    brl_cfg_if.sink   cfg
);

    // Sequencer states.
    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_PROBE  = 4'd2;
    localparam logic [3:0] S_HASH   = 4'd3;
    localparam logic [3:0] S_MOD    = 4'd4;
    localparam logic [3:0] S_BREAD  = 4'd5;
    localparam logic [3:0] S_BCHK   = 4'd6;
    localparam logic [3:0] S_BWRITE = 4'd7;
    localparam logic [3:0] S_WREAD  = 4'd8;
    localparam logic [3:0] S_WCHK   = 4'd9;
    localparam logic [3:0] S_EWRITE = 4'd10;
    localparam logic [3:0] S_DREAD  = 4'd11;
    localparam logic [3:0] S_DCHK   = 4'd12;
    localparam logic [3:0] S_DONE   = 4'd13;

    // What the current hash is for.
    localparam logic [1:0] PH_PROBE  = 2'd0;
    localparam logic [1:0] PH_BUCKET = 2'd1;
    localparam logic [1:0] PH_MARK   = 2'd2;

    // Memories: direct table, Bloom bitmaps and bucketed tables of both groups.
    logic [31:0] dir_mem [2**DIRECT_INDEX_BITS];
    logic        hbl_mem [2**BLOOM_AW];
    logic        nbl_mem [2**BLOOM_AW];
    entry_t      hen_mem [2**ENTRY_AW];
    entry_t      nen_mem [2**ENTRY_AW];

    logic                         dir_we;
    logic [DIRECT_INDEX_BITS-1:0] dir_addr;
    logic [31:0]                  dir_wdata;
    logic [31:0]                  dir_rd;
    logic                         hbl_we, nbl_we;
    logic [BLOOM_AW-1:0]          blm_addr;
    logic                         blm_wdata;
    logic                         hbl_rd, nbl_rd;
    logic                         hen_we, nen_we;
    logic [ENTRY_AW-1:0]          ent_addr;
    entry_t                       ent_wdata;
    entry_t                       hen_rd, nen_rd;

    // Control and context registers.
    logic [3:0]          state_reg, state_next;
    logic [CLR_AW-1:0]   clr_reg, clr_next;
    logic                op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [ADDR_W-1:0]   hop_reg, hop_next;
    logic [ADDR_W-1:0]   key_reg, key_next;
    logic                grp_reg, grp_next;
    logic [1:0]          phase_reg, phase_next;
    logic [31:0]         seed_reg, seed_next;
    logic [31:0]         n_reg, n_next;
    logic [DRAW_W-1:0]   r_reg, r_next;
    logic [1:0]          hk_reg, hk_next;
    logic [DRAW_W-1:0]   dvd_reg, dvd_next;
    logic [DIV_W-1:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]    div_reg, div_next;
    logic [4:0]          mk_reg, mk_next;
    logic [PROBE_W-1:0]  probe_reg, probe_next;
    logic [WAY_AW-1:0]   way_reg, way_next;
    logic [WAY_AW-1:0]   wway_reg, wway_next;
    logic                free_ok_reg, free_ok_next;
    logic                found_reg, found_next;
    logic [ADDR_W-1:0]   nh_reg, nh_next;
    logic                made_reg, made_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                dflt_valid_reg, dflt_valid_next;
    logic [ADDR_W-1:0]   dflt_hop_reg, dflt_hop_next;

    // Configuration registers.
    logic [CNT_W-1:0] host_cnt_reg, net_cnt_reg;
    logic [LEN_W-1:0] host_len_reg, net_len_reg;
    logic [BKT_W-1:0] host_bkt_reg, net_bkt_reg;

    // Output register.
    logic                rsp_valid_reg, rsp_valid_next;
    logic                rsp_found_reg;
    logic [ADDR_W-1:0]   rsp_hop_reg;
    logic                rsp_made_reg;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic                out_load;

    // Datapath helpers.
    logic [CNT_W-1:0]   cnt_raw;
    logic [LEN_W-1:0]   len_raw;
    logic [BKT_W-1:0]   bkt_raw;
    logic [PROBE_W-1:0] cnt_sat;
    logic [DIV_W-1:0]   len_sat;
    logic [DIV_W-1:0]   bkt_sat;
    logic [31:0]        n_mul;
    logic [DRAW_W-1:0]  r_new;
    logic [DIV_W:0]     rem_sh;
    logic [DIV_W:0]     rem_sub;
    logic [DIV_W-1:0]   rem_new;
    entry_t             ent_rd;
    logic               blm_bit;
    logic               key_hit;
    logic               way_last;
    logic               miss;
    logic [ADDR_W-1:0]  store_key;

    always_ff @(posedge clk)
    begin
        if (dir_we)
        begin
            dir_mem[dir_addr] <= dir_wdata;
        end
        dir_rd <= dir_mem[dir_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hbl_we)
        begin
            hbl_mem[blm_addr] <= blm_wdata;
        end
        hbl_rd <= hbl_mem[blm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nbl_we)
        begin
            nbl_mem[blm_addr] <= blm_wdata;
        end
        nbl_rd <= nbl_mem[blm_addr];
    end

    always_ff @(posedge clk)
    begin
        if (hen_we)
        begin
            hen_mem[ent_addr] <= ent_wdata;
        end
        hen_rd <= hen_mem[ent_addr];
    end

    always_ff @(posedge clk)
    begin
        if (nen_we)
        begin
            nen_mem[ent_addr] <= ent_wdata;
        end
        nen_rd <= nen_mem[ent_addr];
    end

    // Per-group settings with out-of-range values folded into range.
    always_comb
    begin
        cnt_raw = grp_reg ? net_cnt_reg : host_cnt_reg;
        len_raw = grp_reg ? net_len_reg : host_len_reg;
        bkt_raw = grp_reg ? net_bkt_reg : host_bkt_reg;
        cnt_sat = (32'(cnt_raw) > MAX_HASHES) ? PROBE_W'(MAX_HASHES) : PROBE_W'(cnt_raw);
        if (len_raw == '0)
        begin
            len_sat = DIV_W'(1);
        end
        else if (32'(len_raw) > BLOOM_BITS)
        begin
            len_sat = DIV_W'(BLOOM_BITS);
        end
        else
        begin
            len_sat = DIV_W'(len_raw);
        end
        if (bkt_raw == '0)
        begin
            bkt_sat = DIV_W'(1);
        end
        else if (32'(bkt_raw) > BUCKETS)
        begin
            bkt_sat = DIV_W'(BUCKETS);
        end
        else
        begin
            bkt_sat = DIV_W'(bkt_raw);
        end
    end

    // One generator step per cycle; the 31-bit draw is assembled over three steps.
    assign n_mul = n_reg * LCG_MUL + LCG_ADD;
    assign r_new = (hk_reg == 2'd0) ? {20'd0, n_mul[26:16]}
                                    : ({r_reg[20:0], 10'd0} ^ {21'd0, n_mul[25:16]});

    // Restoring remainder, one dividend bit per cycle.
    assign rem_sh  = {rem_reg, dvd_reg[DRAW_W-1]};
    assign rem_sub = rem_sh - {1'b0, div_reg};
    assign rem_new = (rem_sh >= {1'b0, div_reg}) ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];

    assign ent_rd    = grp_reg ? nen_rd : hen_rd;
    assign blm_bit   = grp_reg ? nbl_rd : hbl_rd;
    assign key_hit   = ent_rd.valid && (ent_rd.key == key_reg);
    assign way_last  = (way_reg == WAY_AW'(WAYS - 1));
    assign store_key = req.addr & (ALL_ONES << (HOST_PLEN - req.prefix_len));

    assign out_load = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        hop_next        = hop_reg;
        key_next        = key_reg;
        grp_next        = grp_reg;
        phase_next      = phase_reg;
        seed_next       = seed_reg;
        n_next          = n_reg;
        r_next          = r_reg;
        hk_next         = hk_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        div_next        = div_reg;
        mk_next         = mk_reg;
        probe_next      = probe_reg;
        way_next        = way_reg;
        wway_next       = wway_reg;
        free_ok_next    = free_ok_reg;
        found_next      = found_reg;
        nh_next         = nh_reg;
        made_next       = made_reg;
        status_next     = status_reg;
        dflt_valid_next = dflt_valid_reg;
        dflt_hop_next   = dflt_hop_reg;
        miss            = 1'b0;

        dir_we    = 1'b0;
        dir_addr  = addr_reg[ADDR_W-1 -: DIRECT_INDEX_BITS];
        dir_wdata = hop_reg;
        hbl_we    = 1'b0;
        nbl_we    = 1'b0;
        blm_addr  = rem_reg[BLOOM_AW-1:0];
        blm_wdata = 1'b1;
        hen_we    = 1'b0;
        nen_we    = 1'b0;
        ent_addr  = {rem_reg[BUCKET_AW-1:0], way_reg};
        ent_wdata = '{valid: 1'b1, key: key_reg, hop: hop_reg};

        case (state_reg)
            S_CLEAR:
            begin
                dir_we    = 1'b1;
                hbl_we    = 1'b1;
                nbl_we    = 1'b1;
                hen_we    = 1'b1;
                nen_we    = 1'b1;
                dir_addr  = clr_reg[DIRECT_INDEX_BITS-1:0];
                blm_addr  = clr_reg[BLOOM_AW-1:0];
                ent_addr  = clr_reg[ENTRY_AW-1:0];
                dir_wdata = '0;
                blm_wdata = 1'b0;
                ent_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next     = req.op;
                    addr_next   = req.addr;
                    hop_next    = req.hop_in;
                    found_next  = 1'b0;
                    nh_next     = '0;
                    made_next   = 1'b0;
                    status_next = STAT_OK;
                    probe_next  = '0;
                    if (req.op == OP_LOOKUP)
                    begin
                        grp_next   = 1'b0;
                        key_next   = req.addr;
                        seed_next  = req.addr;
                        phase_next = PH_PROBE;
                        state_next = S_PROBE;
                    end
                    else if (req.prefix_len > HOST_PLEN)
                    begin
                        status_next = STAT_BADLEN;
                        state_next  = S_DONE;
                    end
                    else if (req.prefix_len == '0)
                    begin
                        made_next       = !dflt_valid_reg;
                        dflt_valid_next = 1'b1;
                        dflt_hop_next   = req.hop_in;
                        state_next      = S_DONE;
                    end
                    else if (req.prefix_len == DIRECT_PLEN)
                    begin
                        state_next = S_DREAD;
                    end
                    else
                    begin
                        // Group store: search the bucket first, mark Bloom bits after.
                        grp_next   = (req.prefix_len != HOST_PLEN);
                        key_next   = store_key;
                        phase_next = PH_BUCKET;
                        n_next     = store_key;
                        hk_next    = '0;
                        state_next = S_HASH;
                    end
                end
            end

            S_PROBE:
            begin
                if (probe_reg == cnt_sat)
                begin
                    if (phase_reg == PH_MARK)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        phase_next = PH_BUCKET;
                        n_next     = key_reg;
                        hk_next    = '0;
                        state_next = S_HASH;
                    end
                end
                else
                begin
                    n_next     = seed_reg;
                    hk_next    = '0;
                    state_next = S_HASH;
                end
            end

            S_HASH:
            begin
                n_next  = n_mul;
                r_next  = r_new;
                hk_next = hk_reg + 1'b1;
                if (hk_reg == 2'd2)
                begin
                    dvd_next   = r_new;
                    seed_next  = {1'b0, r_new};
                    div_next   = (phase_reg == PH_BUCKET) ? bkt_sat : len_sat;
                    rem_next   = '0;
                    mk_next    = '0;
                    state_next = S_MOD;
                end
            end

            S_MOD:
            begin
                rem_next = rem_new;
                dvd_next = {dvd_reg[DRAW_W-2:0], 1'b0};
                mk_next  = mk_reg + 1'b1;
                if (mk_reg == 5'(DRAW_W - 1))
                begin
                    case (phase_reg)
                        PH_PROBE:
                        begin
                            state_next = S_BREAD;
                        end
                        PH_MARK:
                        begin
                            state_next = S_BWRITE;
                        end
                        default:
                        begin
                            way_next     = '0;
                            free_ok_next = 1'b0;
                            state_next   = S_WREAD;
                        end
                    endcase
                end
            end

            S_BREAD:
            begin
                state_next = S_BCHK;
            end

            S_BCHK:
            begin
                if (!blm_bit)
                begin
                    miss = 1'b1;
                end
                else
                begin
                    probe_next = probe_reg + 1'b1;
                    state_next = S_PROBE;
                end
            end

            S_BWRITE:
            begin
                hbl_we     = !grp_reg;
                nbl_we     = grp_reg;
                probe_next = probe_reg + 1'b1;
                state_next = S_PROBE;
            end

            S_WREAD:
            begin
                state_next = S_WCHK;
            end

            S_WCHK:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    if (key_hit)
                    begin
                        found_next = 1'b1;
                        nh_next    = ent_rd.hop;
                        state_next = S_DONE;
                    end
                    else if (way_last)
                    begin
                        miss = 1'b1;
                    end
                    else
                    begin
                        way_next   = way_reg + 1'b1;
                        state_next = S_WREAD;
                    end
                end
                else if (key_hit)
                begin
                    wway_next  = way_reg;
                    made_next  = 1'b0;
                    state_next = S_EWRITE;
                end
                else
                begin
                    if (!ent_rd.valid && !free_ok_reg)
                    begin
                        free_ok_next = 1'b1;
                        wway_next    = way_reg;
                    end
                    if (way_last)
                    begin
                        if (free_ok_reg || !ent_rd.valid)
                        begin
                            made_next  = 1'b1;
                            state_next = S_EWRITE;
                        end
                        else
                        begin
                            status_next = STAT_FULL;
                            state_next  = S_DONE;
                        end
                    end
                    else
                    begin
                        way_next   = way_reg + 1'b1;
                        state_next = S_WREAD;
                    end
                end
            end

            S_EWRITE:
            begin
                ent_addr   = {rem_reg[BUCKET_AW-1:0], wway_reg};
                hen_we     = !grp_reg;
                nen_we     = grp_reg;
                phase_next = PH_MARK;
                seed_next  = key_reg;
                probe_next = '0;
                state_next = S_PROBE;
            end

            S_DREAD:
            begin
                state_next = S_DCHK;
            end

            S_DCHK:
            begin
                if (op_reg == OP_LOOKUP)
                begin
                    if (dir_rd != '0)
                    begin
                        found_next = 1'b1;
                        nh_next    = dir_rd;
                    end
                    else if (dflt_valid_reg)
                    begin
                        found_next = 1'b1;
                        nh_next    = dflt_hop_reg;
                    end
                end
                else
                begin
                    made_next = (dir_rd == '0);
                    dir_we    = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A lookup that misses the host group falls to the /24 net group, then to
        // the direct table.
        if (miss)
        begin
            if (!grp_reg)
            begin
                grp_next   = 1'b1;
                key_next   = addr_reg & NET24_MASK;
                seed_next  = addr_reg & NET24_MASK;
                probe_next = '0;
                phase_next = PH_PROBE;
                state_next = S_PROBE;
            end
            else
            begin
                state_next = S_DREAD;
            end
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            dflt_valid_reg <= 1'b0;
            dflt_hop_reg   <= '0;
            rsp_valid_reg  <= 1'b0;
            host_cnt_reg   <= CNT_W'(4);
            net_cnt_reg    <= CNT_W'(4);
            host_len_reg   <= LEN_W'(65536);
            net_len_reg    <= LEN_W'(65536);
            host_bkt_reg   <= BKT_W'(16384);
            net_bkt_reg    <= BKT_W'(16384);
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            dflt_valid_reg <= dflt_valid_next;
            dflt_hop_reg   <= dflt_hop_next;
            rsp_valid_reg  <= rsp_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_HOST_CNT: host_cnt_reg <= cfg.data[CNT_W-1:0];
                    REG_NET_CNT:  net_cnt_reg  <= cfg.data[CNT_W-1:0];
                    REG_HOST_LEN: host_len_reg <= cfg.data[LEN_W-1:0];
                    REG_NET_LEN:  net_len_reg  <= cfg.data[LEN_W-1:0];
                    REG_HOST_BKT: host_bkt_reg <= cfg.data[BKT_W-1:0];
                    REG_NET_BKT:  net_bkt_reg  <= cfg.data[BKT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        addr_reg    <= addr_next;
        hop_reg     <= hop_next;
        key_reg     <= key_next;
        grp_reg     <= grp_next;
        phase_reg   <= phase_next;
        seed_reg    <= seed_next;
        n_reg       <= n_next;
        r_reg       <= r_next;
        hk_reg      <= hk_next;
        dvd_reg     <= dvd_next;
        rem_reg     <= rem_next;
        div_reg     <= div_next;
        mk_reg      <= mk_next;
        probe_reg   <= probe_next;
        way_reg     <= way_next;
        wway_reg    <= wway_next;
        free_ok_reg <= free_ok_next;
        found_reg   <= found_next;
        nh_reg      <= nh_next;
        made_reg    <= made_next;
        status_reg  <= status_next;
        if (out_load)
        begin
            rsp_found_reg  <= found_reg;
            rsp_hop_reg    <= found_reg ? nh_reg : '0;
            rsp_made_reg   <= made_reg;
            rsp_status_reg <= status_reg;
        end
    end

    assign req.ready        = (state_reg == S_IDLE);
    assign cfg.ready        = 1'b1;
    assign rsp.valid        = rsp_valid_reg;
    assign rsp.found        = rsp_found_reg;
    assign rsp.next_hop_out = rsp_hop_reg;
    assign rsp.created      = rsp_made_reg;
    assign rsp.status       = rsp_status_reg;

endmodule
